// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
// Used by fixed_block_pool_allocator; depends on nothing.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int unsigned DefPoolBlocks   = 1024;
  localparam int unsigned CountW          = 11;
  localparam int unsigned BytesW          = 13;
  localparam int unsigned CfgDataW        = 13;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned IndexW          = 10;
  localparam int unsigned OffsetW         = 22;
  localparam int unsigned MinBlockBytes   = 8;
  localparam logic [CountW-1:0] RstBlockCount = 11'd1024;
  localparam logic [BytesW-1:0] RstBlockBytes = 13'd64;
  localparam logic [CountW-1:0] InUseMax      = 11'h7FF;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAN = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_REFUSED   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_BLOCK_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_FETCH = 1'b1
  } fsm_e;

endpackage

// ===== rtl/fbpa_link_mem.sv =====
// Free-list link store: one {valid, successor} entry per block.
// Synchronous single-write, single-read memory; no package dependency.
`timescale 1ns / 1ps

module fbpa_link_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: request decode, free-list head
// cache and bump counter. Depends on fbpa_pkg and fbpa_link_mem.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive mode_i / block_index_i and raise start; the beat is
//   taken at a clock edge with start high and busy low. Modes: allocate, free,
//   clean. Configuration (block count, block size) is written through
//   cfg_we_i / cfg_index_i / cfg_wdata_i; the user must write it only while
//   no command is in flight, as the block does not enforce this. Result: one
//   beat per command, on granted_index_o, byte_offset_o, status_o and
//   in_use_count_o, marked by done_o for exactly one cycle, the cycle right
//   after the command is taken. The receiver cannot stall it. Free, clean and
//   allocations served by the bump counter leave busy low. An allocation that
//   pops the free list while more entries follow reads the successor of the
//   new head from the link memory, and busy stays high while that read lands.
//   Reset clears the list head, bump counter, in-use count and restores the
//   configuration defaults; the link memory needs no clearing, since an
//   entry is only read after a free has written it.
module fixed_block_pool_allocator #(
  parameter int unsigned POOL_BLOCKS = fbpa_pkg::DefPoolBlocks
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode_i,
  input  logic [fbpa_pkg::IndexW-1:0]       block_index_i,
  input  logic                              cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output logic                              done_o,
  output logic [fbpa_pkg::IndexW-1:0]       granted_index_o,
  output logic [fbpa_pkg::OffsetW-1:0]      byte_offset_o,
  output logic [1:0]                        status_o,
  output logic [fbpa_pkg::CountW-1:0]       in_use_count_o
);

  localparam int unsigned IdxW = $clog2(POOL_BLOCKS);
  localparam int unsigned CntW = $clog2(POOL_BLOCKS + 1);

  fbpa_pkg::fsm_e               state_q, state_d;
  logic [IdxW-1:0]              head_q, head_d;
  logic                         nonempty_q, nonempty_d;
  logic [IdxW-1:0]              hlink_q, hlink_d;
  logic                         hvalid_q, hvalid_d;
  logic [CntW-1:0]              bump_q, bump_d;
  logic [fbpa_pkg::CountW-1:0]  in_use_q, in_use_d;
  logic [fbpa_pkg::CountW-1:0]  cfg_count_q;
  logic [fbpa_pkg::BytesW-1:0]  cfg_bytes_q;
  logic                         done_q;
  logic [fbpa_pkg::IndexW-1:0]  granted_q, granted_d;
  logic [fbpa_pkg::OffsetW-1:0] offset_q, offset_d;
  fbpa_pkg::status_e            status_q, status_d;

  logic                         accept;
  logic [CntW-1:0]              cap;
  logic [fbpa_pkg::BytesW-1:0]  eff_bytes;
  logic                         got;
  logic [IdxW-1:0]              alloc_idx;
  logic [31:0]                  idx32;
  logic [31:0]                  prod;
  logic                         free_ok;
  logic [IdxW-1:0]              free_idx;
  logic                         mem_we, mem_re;
  logic [IdxW:0]                mem_wdata, mem_rdata;

  assign busy   = (state_q == fbpa_pkg::FSM_FETCH);
  assign accept = start && !busy;

  // capacity = min(block_count, POOL_BLOCKS), zero meaning the whole store
  always_comb begin
    if (cfg_count_q == '0 || 32'(cfg_count_q) > 32'(POOL_BLOCKS)) begin
      cap = CntW'(32'(POOL_BLOCKS));
    end else begin
      cap = CntW'(32'(cfg_count_q));
    end
  end

  assign eff_bytes = (32'(cfg_bytes_q) < 32'(fbpa_pkg::MinBlockBytes)) ?
                     fbpa_pkg::BytesW'(32'(fbpa_pkg::MinBlockBytes)) : cfg_bytes_q;
  assign free_ok   = 32'(block_index_i) < 32'(POOL_BLOCKS);
  assign free_idx  = IdxW'(32'(block_index_i));
  assign idx32     = 32'(alloc_idx);
  assign prod      = idx32 * 32'(eff_bytes);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    nonempty_d = nonempty_q;
    hlink_d    = hlink_q;
    hvalid_d   = hvalid_q;
    bump_d     = bump_q;
    in_use_d   = in_use_q;
    granted_d  = '0;
    offset_d   = '0;
    status_d   = fbpa_pkg::STATUS_OK;
    got        = 1'b0;
    alloc_idx  = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = {nonempty_q, head_q};

    case (state_q)
      fbpa_pkg::FSM_IDLE: begin
        if (accept) begin
          case (fbpa_pkg::mode_e'(mode_i))
            fbpa_pkg::MODE_ALLOC: begin
              if (nonempty_q) begin
                got        = 1'b1;
                alloc_idx  = head_q;
                nonempty_d = hvalid_q;
                head_d     = hvalid_q ? hlink_q : '0;
                // successor of the new head arrives next cycle
                if (hvalid_q) begin
                  mem_re  = 1'b1;
                  state_d = fbpa_pkg::FSM_FETCH;
                end
              end else if (32'(bump_q) < 32'(cap)) begin
                got       = 1'b1;
                alloc_idx = IdxW'(32'(bump_q));
                bump_d    = bump_q + 1'b1;
              end
              if (got) begin
                granted_d = idx32[fbpa_pkg::IndexW-1:0];
                offset_d  = prod[fbpa_pkg::OffsetW-1:0];
                if (in_use_q != fbpa_pkg::InUseMax) begin
                  in_use_d = in_use_q + 1'b1;
                end
              end else begin
                status_d = fbpa_pkg::STATUS_EXHAUSTED;
              end
            end
            fbpa_pkg::MODE_FREE: begin
              if (free_ok) begin
                // push: old head becomes the link; cache it directly
                mem_we     = 1'b1;
                hlink_d    = head_q;
                hvalid_d   = nonempty_q;
                head_d     = free_idx;
                nonempty_d = 1'b1;
                if (in_use_q != '0) begin
                  in_use_d = in_use_q - 1'b1;
                end
              end
            end
            fbpa_pkg::MODE_CLEAN: begin
              if (in_use_q != '0) begin
                status_d = fbpa_pkg::STATUS_REFUSED;
              end else begin
                head_d     = '0;
                nonempty_d = 1'b0;
                bump_d     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      fbpa_pkg::FSM_FETCH: begin
        hvalid_d = mem_rdata[IdxW];
        hlink_d  = mem_rdata[IdxW-1:0];
        state_d  = fbpa_pkg::FSM_IDLE;
      end
      default: begin
        state_d = fbpa_pkg::FSM_IDLE;
      end
    endcase
  end

  // Push writes and pop reads come from different commands, so the memory
  // never sees a read and a write of one entry at the same edge.
  fbpa_link_mem #(
    .DEPTH (POOL_BLOCKS),
    .WIDTH (IdxW + 1)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_idx),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (hlink_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fbpa_pkg::FSM_IDLE;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      hvalid_q   <= 1'b0;
      bump_q     <= '0;
      in_use_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      hvalid_q   <= hvalid_d;
      bump_q     <= bump_d;
      in_use_q   <= in_use_d;
      done_q     <= accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= fbpa_pkg::RstBlockCount;
      cfg_bytes_q <= fbpa_pkg::RstBlockBytes;
    end else if (cfg_we_i) begin
      case (fbpa_pkg::cfg_idx_e'(cfg_index_i))
        fbpa_pkg::CFG_BLOCK_COUNT: cfg_count_q <= cfg_wdata_i[fbpa_pkg::CountW-1:0];
        fbpa_pkg::CFG_BLOCK_BYTES: cfg_bytes_q <= cfg_wdata_i[fbpa_pkg::BytesW-1:0];
        default: begin
        end
      endcase
    end
  end

  // result payload and head link carry no reset
  always_ff @(posedge clk_i) begin
    hlink_q   <= hlink_d;
    granted_q <= granted_d;
    offset_q  <= offset_d;
    status_q  <= status_d;
  end

  assign done_o          = done_q;
  assign granted_index_o = granted_q;
  assign byte_offset_o   = offset_q;
  assign status_o        = status_q;
  assign in_use_count_o  = in_use_q;

  a_exhausted_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_q == fbpa_pkg::STATUS_EXHAUSTED |-> granted_q == '0 && offset_q == '0)
    else $error("exhausted result carries a grant");

  a_fetch_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fbpa_pkg::FSM_FETCH |-> done_o && status_q == fbpa_pkg::STATUS_OK)
    else $error("link fetch without an allocation beat");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nonempty_q |-> head_q == '0)
    else $error("empty free list with nonzero head");

  a_bump_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bump_q) <= 32'(POOL_BLOCKS))
    else $error("bump counter beyond pool");

  a_clean_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_i == fbpa_pkg::MODE_CLEAN && in_use_q == '0
    |=> !nonempty_q && bump_q == '0)
    else $error("granted clean left pool state");

endmodule
